// ----- rtl/sscp_pkg.sv -----
// Shared widths, types and constants for the segment closest-points pipeline.
package sscp_pkg;

    localparam int CW      = 32;             // coordinate width
    localparam int FRAC    = 16;             // fraction bits of every fixed-point value
    localparam int DIFF_W  = CW + 1;         // exact difference of two coordinates
    localparam int PROD_W  = 2 * DIFF_W;     // product of two differences
    localparam int SUM_W   = PROD_W + 2;     // sum of three products
    localparam int DOT_W   = SUM_W - FRAC;   // dot product in fixed point
    localparam int WIDE_W  = 2 * DOT_W + 1;  // difference of two dot-product products
    localparam int MU_W    = FRAC + 1;       // line parameter in [0, 1]
    localparam int EPS_W   = 16;             // zero threshold register

    localparam int MUL_LAT = 2;              // split multiplier latency
    localparam int DIV_LAT = FRAC + 1;       // ratio divider latency

    typedef logic signed [CW-1:0]     coord_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [MU_W-1:0]          mu_t;

    localparam mu_t MU_ONE = {1'b1, {FRAC{1'b0}}};

endpackage

// ----- rtl/segment_segment_closest_points.sv -----
// Closest points between two 3-D segments in signed Q16.16: a fully pipelined kernel
// that accepts one item per clock unless the output stalls and returns one item per
// item, in order. The latency is set by the two 17-stage ratio dividers in series (the
// solve for the line parameters and the re-projection for parallel segments) plus the
// split multipliers around them. The whole pipeline advances together; when the output
// item is not taken, every stage holds and s_tready drops, so nothing is lost or
// repeated. The zero threshold resets to 1; the user writes it through cfg_wr_en and
// cfg_wr_data only while no item is in flight, which the block does not enforce.
// Lengths and the determinant count as zero when they lie strictly between minus and
// plus the threshold (the determinant against the threshold shifted up by 16 bits).
module segment_segment_closest_points (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // From the lowest bit: first_start_x/y/z, first_end_x/y/z,
    // second_start_x/y/z, second_end_x/y/z, 32 bits each.
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // From the lowest bit: near_first_x/y/z, near_second_x/y/z, 32 bits each.
    output logic [191:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);
    import sscp_pkg::*;

    localparam int LAST = 53;
    localparam int NW   = DOT_W + 1;
    localparam int WW   = WIDE_W + 1;

    // Fold three products into a dot product, optionally negating the exact sum
    // before the floor shift.
    function automatic dot_t dot_fold(input prod_t p0, input prod_t p1, input prod_t p2,
                                      input logic neg);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
        if (neg) begin
            s = -s;
        end
        return s[SUM_W-1:FRAC];
    endfunction

    // Start point plus scaled direction, saturated to the coordinate range.
    function automatic coord_t along_pt(input coord_t o, input prod_t pr);
        logic signed [PROD_W-FRAC:0] s;
        s = (PROD_W-FRAC+1)'(o) + (PROD_W-FRAC+1)'($signed(pr[PROD_W-1:FRAC]));
        if (s[PROD_W-FRAC:CW-1] != {(PROD_W-FRAC-CW+2){s[PROD_W-FRAC]}}) begin
            return s[PROD_W-FRAC] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return s[CW-1:0];
    endfunction

    logic               en;
    logic               vld_reg [1:LAST];
    logic [EPS_W-1:0]   eps_reg;
    dot_t               eps_d;
    wide_t              lim;

    assign en       = !vld_reg[LAST] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAST];
    assign eps_d    = $signed({{(DOT_W-EPS_W){1'b0}}, eps_reg});
    assign lim      = $signed({{(WIDE_W-EPS_W-FRAC){1'b0}}, eps_reg, {FRAC{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(1);
        end else if (cfg_wr_en) begin
            eps_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= LAST; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int i = 2; i <= LAST; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 1: coordinates and exact difference vectors.
    coord_t in_s1 [3], in_e1 [3], in_s2 [3], in_e2 [3];
    coord_t s1_reg [3], s2_reg [3];
    diff_t  d1_reg [3], d2_reg [3], d3_reg [3], d4_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_s1[i] = s_tdata[CW*i +: CW];
            in_e1[i] = s_tdata[CW*(3+i) +: CW];
            in_s2[i] = s_tdata[CW*(6+i) +: CW];
            in_e2[i] = s_tdata[CW*(9+i) +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_reg[i] <= in_s1[i];
                s2_reg[i] <= in_s2[i];
                d1_reg[i] <= DIFF_W'(in_s2[i]) - DIFF_W'(in_s1[i]);
                d2_reg[i] <= DIFF_W'(in_e1[i]) - DIFF_W'(in_s1[i]);
                d3_reg[i] <= DIFF_W'(in_e2[i]) - DIFF_W'(in_s2[i]);
                d4_reg[i] <= DIFF_W'(in_e2[i]) - DIFF_W'(in_s1[i]);
            end
        end
    end

    // Stages 2-3: the eighteen products of the six dot products A, B, C, D, E, F.
    diff_t ma [18], mb [18];
    prod_t mp [18];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ma[i]    = d1_reg[i]; mb[i]    = d2_reg[i];
            ma[3+i]  = d2_reg[i]; mb[3+i]  = d3_reg[i];
            ma[6+i]  = d2_reg[i]; mb[6+i]  = d2_reg[i];
            ma[9+i]  = d3_reg[i]; mb[9+i]  = d3_reg[i];
            ma[12+i] = d1_reg[i]; mb[12+i] = d3_reg[i];
            ma[15+i] = d4_reg[i]; mb[15+i] = d2_reg[i];
        end
    end

    for (genvar g = 0; g < 18; g++) begin : g_dot_mul
        sscp_mul #(.W(DIFF_W)) u_mul (.aclk, .en, .a(ma[g]), .b(mb[g]), .p(mp[g]));
    end

    // Stage 4: dot products. G is the dot of S1-S2 with the second direction.
    dot_t a4_reg, b4_reg, c4_reg, d4s_reg, e4_reg, f4_reg, g4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a4_reg  <= dot_fold(mp[0],  mp[1],  mp[2],  1'b0);
            b4_reg  <= dot_fold(mp[3],  mp[4],  mp[5],  1'b0);
            c4_reg  <= dot_fold(mp[6],  mp[7],  mp[8],  1'b0);
            d4s_reg <= dot_fold(mp[9],  mp[10], mp[11], 1'b0);
            e4_reg  <= dot_fold(mp[12], mp[13], mp[14], 1'b0);
            f4_reg  <= dot_fold(mp[15], mp[16], mp[17], 1'b0);
            g4_reg  <= dot_fold(mp[12], mp[13], mp[14], 1'b1);
        end
    end

    // Stages 5-6: products for the determinant and both numerators.
    dot_t                     m2a [6], m2b [6];
    logic signed [2*DOT_W-1:0] m2p [6];

    always_comb begin
        m2a[0] = c4_reg; m2b[0] = d4s_reg;
        m2a[1] = b4_reg; m2b[1] = b4_reg;
        m2a[2] = a4_reg; m2b[2] = d4s_reg;
        m2a[3] = e4_reg; m2b[3] = b4_reg;
        m2a[4] = a4_reg; m2b[4] = b4_reg;
        m2a[5] = c4_reg; m2b[5] = e4_reg;
    end

    for (genvar g = 0; g < 6; g++) begin : g_det_mul
        sscp_mul #(.W(DOT_W)) u_mul (.aclk, .en, .a(m2a[g]), .b(m2b[g]), .p(m2p[g]));
    end

    logic [5*DOT_W-1:0] dots6_v;
    dot_t               a6, c6, d6, f6, g6;
    wide_t              det6;

    sscp_dly #(.W(5*DOT_W), .N(MUL_LAT)) u_dly_dots (
        .aclk, .en, .d({g4_reg, f4_reg, d4s_reg, c4_reg, a4_reg}), .q(dots6_v));

    assign a6   = dots6_v[0*DOT_W +: DOT_W];
    assign c6   = dots6_v[1*DOT_W +: DOT_W];
    assign d6   = dots6_v[2*DOT_W +: DOT_W];
    assign f6   = dots6_v[3*DOT_W +: DOT_W];
    assign g6   = dots6_v[4*DOT_W +: DOT_W];
    assign det6 = WIDE_W'(m2p[0]) - WIDE_W'(m2p[1]);

    // Stage 7: determinant, numerators and the case flags.
    wide_t det7_reg, numf7_reg, nums7_reg;
    dot_t  a7_reg, c7_reg, d7_reg, f7_reg, g7_reg;
    logic  nzc7_reg, nzd7_reg, par7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det7_reg  <= det6;
            numf7_reg <= WIDE_W'(m2p[2]) - WIDE_W'(m2p[3]);
            nums7_reg <= WIDE_W'(m2p[4]) - WIDE_W'(m2p[5]);
            a7_reg    <= a6;
            c7_reg    <= c6;
            d7_reg    <= d6;
            f7_reg    <= f6;
            g7_reg    <= g6;
            nzc7_reg  <= (c6 < eps_d) && (c6 > -eps_d);
            nzd7_reg  <= (d6 < eps_d) && (d6 > -eps_d);
            par7_reg  <= (det6 < lim) && (det6 > -lim);
        end
    end

    // Stages 8-24: all first-pass line parameters.
    mu_t ra, rf, rg, rmf, rms;

    sscp_div #(.W(NW)) u_div_a (.aclk, .en, .num(NW'(a7_reg)), .den(NW'(c7_reg)), .mu(ra));
    sscp_div #(.W(NW)) u_div_f (.aclk, .en, .num(NW'(f7_reg)), .den(NW'(c7_reg)), .mu(rf));
    sscp_div #(.W(NW)) u_div_g (.aclk, .en, .num(NW'(g7_reg)), .den(NW'(d7_reg)), .mu(rg));
    sscp_div #(.W(WW)) u_div_mf (
        .aclk, .en, .num(WW'(numf7_reg)), .den(WW'(det7_reg)), .mu(rmf));
    sscp_div #(.W(WW)) u_div_ms (
        .aclk, .en, .num(WW'(nums7_reg)), .den(WW'(det7_reg)), .mu(rms));

    logic [2:0] flg24_v;
    logic       nzc24, nzd24, par24;

    sscp_dly #(.W(3), .N(DIV_LAT)) u_dly_flg (
        .aclk, .en, .d({par7_reg, nzd7_reg, nzc7_reg}), .q(flg24_v));

    assign nzc24 = flg24_v[0];
    assign nzd24 = flg24_v[1];
    assign par24 = flg24_v[2];

    // Stage 25: pick the parameter for each segment. A degenerate segment uses a
    // parameter of zero, which leaves its start point unchanged.
    logic [MU_W:0] mid_sum;
    mu_t           mu1_reg, mu2p_reg;
    logic          nzc25_reg;

    assign mid_sum = {1'b0, ra} + {1'b0, rf};

    always_ff @(posedge aclk) begin
        if (en) begin
            nzc25_reg <= nzc24;
            if (nzc24) begin
                mu1_reg  <= '0;
                mu2p_reg <= nzd24 ? '0 : rg;
            end else if (nzd24) begin
                mu1_reg  <= ra;
                mu2p_reg <= '0;
            end else if (par24) begin
                mu1_reg  <= mid_sum[MU_W:1];
                mu2p_reg <= '0;
            end else begin
                mu1_reg  <= rmf;
                mu2p_reg <= rms;
            end
        end
    end

    // Stages 26-28: point on the first segment.
    logic [3*DIFF_W-1:0] d2_25_v;
    logic [3*CW-1:0]     s1_27_v;
    prod_t               pa1 [3];

    sscp_dly #(.W(3*DIFF_W), .N(24)) u_dly_d2 (
        .aclk, .en, .d({d2_reg[2], d2_reg[1], d2_reg[0]}), .q(d2_25_v));
    sscp_dly #(.W(3*CW), .N(26)) u_dly_s1 (
        .aclk, .en, .d({s1_reg[2], s1_reg[1], s1_reg[0]}), .q(s1_27_v));

    for (genvar g = 0; g < 3; g++) begin : g_p1_mul
        sscp_mul #(.W(DIFF_W)) u_mul (
            .aclk, .en, .a(d2_25_v[g*DIFF_W +: DIFF_W]),
            .b($signed({{(DIFF_W-MU_W){1'b0}}, mu1_reg})), .p(pa1[g]));
    end

    coord_t p1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= along_pt(s1_27_v[i*CW +: CW], pa1[i]);
            end
        end
    end

    // Stages 29-32: for parallel segments, project that point onto the second.
    logic [3*CW-1:0]     s2_28_v, s2_52_v;
    logic [3*DIFF_W-1:0] d3_29_v, d3_50_v;
    diff_t               t_reg [3];
    prod_t               pt [3];
    dot_t                g2_reg;

    sscp_dly #(.W(3*CW), .N(27)) u_dly_s2a (
        .aclk, .en, .d({s2_reg[2], s2_reg[1], s2_reg[0]}), .q(s2_28_v));
    sscp_dly #(.W(3*CW), .N(24)) u_dly_s2b (.aclk, .en, .d(s2_28_v), .q(s2_52_v));
    sscp_dly #(.W(3*DIFF_W), .N(28)) u_dly_d3a (
        .aclk, .en, .d({d3_reg[2], d3_reg[1], d3_reg[0]}), .q(d3_29_v));
    sscp_dly #(.W(3*DIFF_W), .N(21)) u_dly_d3b (.aclk, .en, .d(d3_29_v), .q(d3_50_v));

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= DIFF_W'(p1_reg[i]) - DIFF_W'($signed(s2_28_v[i*CW +: CW]));
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_t_mul
        sscp_mul #(.W(DIFF_W)) u_mul (
            .aclk, .en, .a(t_reg[g]), .b(d3_29_v[g*DIFF_W +: DIFF_W]), .p(pt[g]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g2_reg <= dot_fold(pt[0], pt[1], pt[2], 1'b0);
        end
    end

    // Stages 33-49: second-pass parameter. The parallel case only applies when
    // neither segment is degenerate.
    logic [DOT_W-1:0] d32_v;
    mu_t              r2;
    logic [0:0]       par49_v;
    logic [MU_W-1:0]  mu2p49_v;

    sscp_dly #(.W(DOT_W), .N(25)) u_dly_dd (.aclk, .en, .d(d7_reg), .q(d32_v));
    sscp_div #(.W(NW)) u_div_2 (
        .aclk, .en, .num(NW'(g2_reg)), .den(NW'($signed(d32_v))), .mu(r2));
    sscp_dly #(.W(1), .N(25)) u_dly_par (
        .aclk, .en, .d(par24 && !nzc24 && !nzd24), .q(par49_v));
    sscp_dly #(.W(MU_W), .N(24)) u_dly_mu2 (.aclk, .en, .d(mu2p_reg), .q(mu2p49_v));

    // Stages 50-53: point on the second segment and the output register.
    mu_t             mu2_reg;
    prod_t           pa2 [3];
    logic [3*CW-1:0] p1_52_v;
    coord_t          p2 [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            mu2_reg <= par49_v[0] ? r2 : mu2p49_v;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_p2_mul
        sscp_mul #(.W(DIFF_W)) u_mul (
            .aclk, .en, .a(d3_50_v[g*DIFF_W +: DIFF_W]),
            .b($signed({{(DIFF_W-MU_W){1'b0}}, mu2_reg})), .p(pa2[g]));
    end

    sscp_dly #(.W(3*CW), .N(24)) u_dly_p1 (
        .aclk, .en, .d({p1_reg[2], p1_reg[1], p1_reg[0]}), .q(p1_52_v));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p2[i] = along_pt(s2_52_v[i*CW +: CW], pa2[i]);
        end
    end

    logic [6*CW-1:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {p2[2], p2[1], p2[0], p1_52_v};
        end
    end

    assign m_tdata = out_reg;

    // A selected first-segment parameter never leaves [0, 1].
    a_mu1_range : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[25] |-> (mu1_reg <= MU_ONE))
        else $error("first-segment parameter above one");

    // A degenerate first segment keeps its start point.
    a_nzc_mu1 : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[25] && nzc25_reg |-> (mu1_reg == '0))
        else $error("degenerate first segment moved its start point");

    // An item in the stage before the output register reaches the output when the pipeline moves.
    a_out_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAST-1] |=> m_tvalid)
        else $error("item lost before the output register");
endmodule

// ----- rtl/sscp_mul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
module sscp_mul #(
    parameter int W = 33
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    localparam int K  = W / 2;
    localparam int H  = W - K;
    localparam int PW = 2 * W;

    logic signed [K:0]     al, bl;
    logic signed [H-1:0]   ah, bh;
    logic signed [2*K+1:0] ll_reg;
    logic signed [W:0]     lh_reg, hl_reg;
    logic signed [2*H-1:0] hh_reg;
    logic signed [PW-1:0]  sum;

    assign al = {1'b0, a[K-1:0]};
    assign bl = {1'b0, b[K-1:0]};
    assign ah = a[W-1:K];
    assign bh = b[W-1:K];

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= al * bl;
            lh_reg <= al * bh;
            hl_reg <= ah * bl;
            hh_reg <= ah * bh;
        end
    end

    always_comb begin
        sum = (PW'(hh_reg) <<< (2 * K)) + ((PW'(lh_reg) + PW'(hl_reg)) <<< K) + PW'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p <= sum;
        end
    end
endmodule

// ----- rtl/sscp_div.sv -----
// Pipelined restoring divider giving floor(num/den) in [0, 1], one quotient bit per stage after the first.
module sscp_div #(
    parameter int W = 53
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [W-1:0]      num,
    input  logic signed [W-1:0]      den,
    output sscp_pkg::mu_t            mu
);
    import sscp_pkg::*;

    logic [W-2:0]  r_reg  [0:FRAC];
    logic [W-2:0]  d_reg  [0:FRAC];
    logic [FRAC-1:0] q_reg [0:FRAC];
    logic          zf_reg [0:FRAC];
    logic          of_reg [0:FRAC];

    logic signed [W-1:0] nn, dn;
    logic                zero_f, one_f;
    logic [W-1:0]        sh [0:FRAC-1];
    logic                ge [0:FRAC-1];
    logic [W-2:0]        rn [0:FRAC-1];
    logic [W-1:0]        dif;

    // Sign normalization: a negative divisor flips both operands.
    always_comb begin
        nn     = den[W-1] ? -num : num;
        dn     = den[W-1] ? -den : den;
        zero_f = (den == '0) || nn[W-1] || (nn == '0);
        one_f  = !zero_f && ($unsigned(nn) >= $unsigned(dn));
    end

    always_comb begin
        for (int i = 0; i < FRAC; i++) begin
            dif   = '0;
            sh[i] = {r_reg[i], 1'b0};
            ge[i] = sh[i] >= {1'b0, d_reg[i]};
            dif   = sh[i] - {1'b0, d_reg[i]};
            rn[i] = ge[i] ? dif[W-2:0] : sh[i][W-2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= nn[W-2:0];
            d_reg[0]  <= dn[W-2:0];
            q_reg[0]  <= '0;
            zf_reg[0] <= zero_f;
            of_reg[0] <= one_f;
            for (int i = 0; i < FRAC; i++) begin
                r_reg[i+1]  <= rn[i];
                d_reg[i+1]  <= d_reg[i];
                q_reg[i+1]  <= {q_reg[i][FRAC-2:0], ge[i]};
                zf_reg[i+1] <= zf_reg[i];
                of_reg[i+1] <= of_reg[i];
            end
        end
    end

    assign mu = zf_reg[FRAC] ? '0 : (of_reg[FRAC] ? MU_ONE : {1'b0, q_reg[FRAC]});
endmodule

// ----- rtl/sscp_dly.sv -----
// Enabled delay line that carries side data alongside the arithmetic stages.
module sscp_dly #(
    parameter int W = 32,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sr_reg [0:N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[N-1];
endmodule

// ----- dv/sscp_checker.sv -----
// Watches both item channels, predicts the closest points and compares every result.
module sscp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [383:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    output int           fail_count,
    output int           in_flight,
    output int           checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import sscp_pkg::*;

    typedef logic signed [255:0] big_t;

    localparam big_t VEC_MAX = (big_t'(1) <<< 62) - 1;
    localparam big_t CRD_MAX = (big_t'(1) <<< (CW - 1)) - 1;
    localparam big_t ONE_Q   = big_t'(1) <<< FRAC;

    logic [15:0]  eps_reg;
    logic [191:0] predicted_points[$];

    function automatic big_t clip(big_t a, big_t lo, big_t hi);
        if (a > hi) return hi;
        if (a < lo) return lo;
        return a;
    endfunction

    function automatic big_t dot(big_t u[3], big_t v[3]);
        big_t s;
        s = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        return clip(s >>> FRAC, -VEC_MAX, VEC_MAX);
    endfunction

    // Floor of num/den as a line parameter, held to [0, 1].
    function automatic big_t param_of(big_t num, big_t den);
        if (den == 0) return 0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) return 0;
        if (num >= den) return ONE_Q;
        return (num <<< FRAC) / den;
    endfunction

    function automatic void walk(big_t o[3], big_t v[3], big_t mu, output big_t p[3]);
        for (int i = 0; i < 3; i++)
            p[i] = clip(o[i] + ((v[i] * mu) >>> FRAC), -CRD_MAX - 1, CRD_MAX);
    endfunction

    function automatic bit is_small(big_t x, big_t e);
        return x > -e && x < e;
    endfunction

    // Projects point c onto the segment from o along v (squared length len2).
    function automatic void project(big_t o[3], big_t v[3], big_t len2, big_t c[3],
                                    big_t e, output big_t p[3]);
        big_t t[3];
        if (is_small(len2, e)) begin
            p = o;
            return;
        end
        for (int i = 0; i < 3; i++) t[i] = c[i] - o[i];
        walk(o, v, param_of(dot(t, v), len2), p);
    endfunction

    function automatic logic [191:0] closest_pair(logic [383:0] d, logic [15:0] eps);
        big_t s1[3], e1[3], s2[3], e2[3], r12[3], dir1[3], dir2[3], r4[3];
        big_t p1[3], p2[3];
        big_t a, b, c, dd, e, det, lim, e_big, mu_a, mu_b;
        logic [191:0] res;
        e_big = big_t'(eps);
        for (int i = 0; i < 3; i++) begin
            s1[i] = $signed(d[i*32 +: 32]);
            e1[i] = $signed(d[(3+i)*32 +: 32]);
            s2[i] = $signed(d[(6+i)*32 +: 32]);
            e2[i] = $signed(d[(9+i)*32 +: 32]);
            r12[i]  = s2[i] - s1[i];
            dir1[i] = e1[i] - s1[i];
            dir2[i] = e2[i] - s2[i];
            r4[i]   = e2[i] - s1[i];
        end
        a  = dot(r12, dir1);
        b  = dot(dir1, dir2);
        c  = dot(dir1, dir1);
        dd = dot(dir2, dir2);
        e  = dot(r12, dir2);
        if (is_small(c, e_big)) begin
            p1 = s1;
            project(s2, dir2, dd, s1, e_big, p2);
        end else if (is_small(dd, e_big)) begin
            project(s1, dir1, c, s2, e_big, p1);
            p2 = s2;
        end else begin
            det = c * dd - b * b;
            lim = e_big <<< FRAC;
            if (det < lim && det > -lim) begin
                // Parallel: midpoint of both projected ends, then back onto the second.
                mu_a = param_of(a, c);
                mu_b = param_of(dot(r4, dir1), c);
                walk(s1, dir1, (mu_a + mu_b) >>> 1, p1);
                project(s2, dir2, dd, p1, e_big, p2);
            end else begin
                walk(s1, dir1, param_of(a * dd - e * b, det), p1);
                walk(s2, dir2, param_of(a * b - c * e, det), p2);
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i*32 +: 32]     = p1[i][31:0];
            res[(3+i)*32 +: 32] = p2[i][31:0];
        end
        return res;
    endfunction

    string field_names[6] = '{"near_first_x", "near_first_y", "near_first_z",
                              "near_second_x", "near_second_y", "near_second_z"};

    always @(posedge aclk) begin
        logic [191:0] want;
        if (!aresetn) begin
            eps_reg <= 16'd1;
        end else begin
            if (cfg_wr_en) eps_reg <= cfg_wr_data;
            if (s_tvalid && s_tready) predicted_points.push_back(closest_pair(s_tdata, eps_reg));
            if (m_tvalid && m_tready) begin
                checked++;
                if (predicted_points.size() == 0) begin
                    $error("result item arrived with nothing outstanding");
                    fail_count++;
                end else begin
                    want = predicted_points.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_tdata[i*32 +: 32] !== want[i*32 +: 32]) begin
                            $error("%s: expected %0d, got %0d", field_names[i],
                                   $signed(want[i*32 +: 32]), $signed(m_tdata[i*32 +: 32]));
                            fail_count++;
                        end
                end
            end
        end
        in_flight <= predicted_points.size();
    end

    initial begin
        fail_count = 0;
        in_flight  = 0;
        checked    = 0;
    end

endmodule

// ----- dv/segment_segment_closest_points_test.sv -----
// Top of the closest-points testbench: clock, reset, stimulus and the final verdict.
module segment_segment_closest_points_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth (LAST in the block) with some margin.
    localparam int DRAIN = 70;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    int           fail_count;
    int           in_flight;
    int           checked;
    bit           steady;   // when set, neither side idles
    int           sent;

    segment_segment_closest_points u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    sscp_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .in_flight(in_flight), .checked(checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver holds m_tready low about 19 times in a hundred, except in the steady stretch.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    // Packs two segments into one item, first field in the lowest bits.
    function automatic logic [383:0] pack(logic [31:0] c[12]);
        logic [383:0] d;
        for (int i = 0; i < 12; i++) d[i*32 +: 32] = c[i];
        return d;
    endfunction

    // Offers one item and returns at the falling edge after it was taken.
    // Called at a falling edge; the sender may idle first.
    task automatic send_item(logic [383:0] d);
        while (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    // Lets every outstanding result come back and the pipeline empty out.
    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (in_flight != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    // The threshold is only changed while no item is in flight.
    task automatic set_epsilon(logic [15:0] value);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] any_coord(int kind);
        case (kind)
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(65535 * 64)) - 65535 * 32);
            default: return 32'($signed($urandom_range(4095)) - 2048);
        endcase
    endfunction

    // Builds a random segment pair. Most items are ordinary well-scaled geometry;
    // the rest are degenerate, parallel, near-parallel or full-range noise.
    function automatic logic [383:0] random_pair();
        logic [31:0] c[12];
        int          shape;
        int          scale;
        int          k;
        shape = $urandom_range(99);
        scale = (shape < 15) ? 0 : ((shape < 60) ? 1 : 2);
        for (int i = 0; i < 12; i++) c[i] = any_coord(scale);
        if (shape >= 60 && shape < 70) begin
            for (int i = 0; i < 3; i++) c[3+i] = c[i] + $urandom_range(1);
        end else if (shape >= 70 && shape < 78) begin
            for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + $urandom_range(1);
        end else if (shape >= 78 && shape < 92) begin
            // Second segment parallel to the first, scaled by a small integer.
            k = $signed($urandom_range(6)) - 3;
            if (k == 0) k = 1;
            for (int i = 0; i < 3; i++)
                c[9+i] = c[6+i] + 32'(k * $signed(c[3+i] - c[i]));
            if (shape >= 88) c[9] = c[9] + $urandom_range(3);
        end
        return pack(c);
    endfunction

    task automatic directed_items();
        logic [31:0] c[12];
        logic [31:0] ends[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        // Both segments zero length, with every coordinate at each extreme, at zero and at minus one.
        foreach (ends[j]) begin
            for (int i = 0; i < 12; i++) c[i] = ends[j];
            send_item(pack(c));
        end
        // Opposite corners of the full range on each segment.
        for (int i = 0; i < 12; i++) c[i] = ((i / 3) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_item(pack(c));
        for (int i = 0; i < 12; i++) c[i] = ((i / 3) == 1 || (i / 3) == 2)
                                            ? 32'h7FFF_FFFF : 32'h8000_0000;
        send_item(pack(c));
        // First segment a point, second along x.
        c = '{32'h1_0000, 32'h2_0000, 0, 32'h1_0000, 32'h2_0000, 0,
              0, 0, 0, 32'h4_0000, 0, 0};
        send_item(pack(c));
        // Second segment a point above the first.
        c = '{0, 0, 0, 32'h4_0000, 0, 0,
              32'h3_0000, 32'h1_0000, 32'h1_0000, 32'h3_0000, 32'h1_0000, 32'h1_0000};
        send_item(pack(c));
        // Parallel and overlapping, then parallel and opposite in direction.
        c = '{0, 0, 0, 32'h4_0000, 0, 0,
              32'h1_0000, 32'h1_0000, 0, 32'h6_0000, 32'h1_0000, 0};
        send_item(pack(c));
        c = '{0, 0, 0, 32'h4_0000, 0, 0,
              32'h6_0000, 32'h1_0000, 0, 32'hFFFE_0000, 32'h1_0000, 0};
        send_item(pack(c));
        // Crossing segments, and skew segments whose parameters both clamp.
        c = '{0, 0, 0, 32'h4_0000, 0, 0,
              32'h2_0000, 32'hFFFE_0000, 32'h1_0000, 32'h2_0000, 32'h2_0000, 32'h1_0000};
        send_item(pack(c));
        c = '{0, 0, 0, 32'h1_0000, 0, 0,
              32'h5_0000, 32'h3_0000, 0, 32'h5_0000, 32'h7_0000, 32'h1_0000};
        send_item(pack(c));
        c = '{0, 0, 0, 32'h1_0000, 0, 0,
              32'hFFFB_0000, 32'hFFFD_0000, 0, 32'hFFFB_0000, 32'hFFF9_0000, 32'h1_0000};
        send_item(pack(c));
        // Tiny segments that sit right at the threshold.
        c = '{0, 0, 0, 32'h100, 0, 0, 0, 32'h1_0000, 0, 32'h100, 32'h1_0000, 0};
        send_item(pack(c));
        c = '{0, 0, 0, 32'h1, 32'h1, 0, 32'h5, 0, 0, 32'h5, 32'h1, 32'h1};
        send_item(pack(c));
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        steady      = 1'b0;
        sent        = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset threshold first, then the directed set under each extreme setting.
        directed_items();
        set_epsilon(16'd0);
        directed_items();
        set_epsilon(16'hFFFF);
        directed_items();
        set_epsilon(16'd1);

        // Random items over several threshold settings.
        for (int phase = 0; phase < 5; phase++) begin
            for (int n = 0; n < 270; n++) begin
                steady = (phase == 2 && n >= 60 && n < 200);
                send_item(random_pair());
                // Sender holds off once mid-phase until the pipeline has emptied.
                if (phase == 1 && n == 130) drain_all();
            end
            steady = 1'b0;
            case (phase)
                0:       set_epsilon(16'd0);
                1:       set_epsilon(16'($urandom()));
                2:       set_epsilon(16'hFFFF);
                default: set_epsilon(16'($urandom_range(255)));
            endcase
        end
        drain_all();

        $display("Ran %0d segment pairs and checked %0d result items,", sent, checked);
        $display("covering degenerate, parallel and skew cases under five thresholds.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
